>>> src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BTI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bti_pkg.sv
`timescale 1ns / 1ps

package bti_pkg;

  localparam int VAL_W      = 32;
  localparam int DELTA_W    = 33;
  localparam int NUM_W      = 100;
  localparam int DEN_W      = 64;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_STEPS  = DELTA_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_X_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_COUNT = 2'd1;
  localparam logic [CNT_W-1:0]     COUNT_RESET = 5'd2;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_WR_X    = 2'd1,
    CMD_WR_Y    = 2'd2,
    CMD_WR_GRID = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_RDLO, S_RDHI, S_CAPHI
  } srch_e;

  typedef enum logic [1:0] {
    M_IDLE, M_RUN, M_SIGN
  } mul_e;

  typedef enum logic {
    D_IDLE, D_RUN
  } div_e;

  typedef enum logic [3:0] {
    C_IDLE, C_SEARCH, C_GRD, C_MULF, C_WAITF, C_MULD, C_WAITD,
    C_DEN, C_WDEN, C_DIV, C_WDIV, C_ROUND, C_OUT
  } ctl_e;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } srch_stat_t;

  function automatic logic signed [DELTA_W-1:0] sx_delta(input logic signed [VAL_W-1:0] v);
    return {v[VAL_W-1], v};
  endfunction

  function automatic logic signed [NUM_W-1:0] sx_val(input logic signed [VAL_W-1:0] v);
    return {{(NUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [NUM_W-1:0] sx_dlt(input logic signed [DELTA_W-1:0] v);
    return {{(NUM_W-DELTA_W){v[DELTA_W-1]}}, v};
  endfunction

endpackage

>>> src/bti_if.sv
`timescale 1ns / 1ps

interface bti_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           command;
  logic signed [bti_pkg::VAL_W-1:0]     query_x;
  logic signed [bti_pkg::VAL_W-1:0]     query_y;
  logic [3:0]                           row_index;
  logic [3:0]                           column_index;
  logic signed [bti_pkg::VAL_W-1:0]     entry_value;
  modport source(output valid, command, query_x, query_y, row_index, column_index,
                 entry_value, input ready);
  modport sink(input valid, command, query_x, query_y, row_index, column_index,
               entry_value, output ready);
endinterface

interface bti_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bti_pkg::VAL_W-1:0] result_value;
  logic                             saturated;
  logic                             degenerate;
  modport source(output valid, result_value, saturated, degenerate, input ready);
  modport sink(input valid, result_value, saturated, degenerate, output ready);
endinterface

interface bti_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bti_pkg::CFG_IDX_W-1:0]     index;
  logic [bti_pkg::CFG_DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/bilinear_table_interpolator_top.sv
`timescale 1ns / 1ps
// Bilinear lookup table, signed Q16.16.
// in_i: one beat per item. command selects a query or a write of an x
//   breakpoint, a y breakpoint or a grid value. A write gives no result and
//   leaves in_i ready for the next item; out-of-range indexes are dropped.
// out_o: one beat per query: result_value, saturated, degenerate.
// cfg_i: register writes (index 0 x_axis_count, 1 y_axis_count), always
//   ready; write only while no query is in flight (the block does not enforce it).
// A query is worked in these steps: the axis scans compare the breakpoints in turn
// (both axes in parallel) and then fetch the interval, then nine products run on
// the bit-serial multiplier with a grid read per term, then the 100-step
// restoring divider, then a round and a load into the output register. A
// degenerate interval skips the arithmetic. in_i.ready is low throughout.
// The result waits in an output register; a write or the next query may be
// taken while it waits, and a finished query holds until that register is
// free, so a stalled receiver stalls that query and every item after it.
// Reset clears the counts to 2 and idles the sequencer; tables hold
// nothing until written.
module bilinear_table_interpolator_top #(
  parameter int X_POINTS = 16,
  parameter int Y_POINTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bti_cfg_if.sink   cfg_i,
  bti_in_if.sink    in_i,
  bti_out_if.source out_o
);

  localparam int XIW = $clog2(X_POINTS);
  localparam int YIW = $clog2(Y_POINTS);
  localparam int VW  = bti_pkg::VAL_W;
  localparam int DW  = bti_pkg::DELTA_W;
  localparam int NW  = bti_pkg::NUM_W;
  localparam int RW  = bti_pkg::DEN_W;

  logic [bti_pkg::CNT_W-1:0] x_cnt_q, y_cnt_q;
  bti_pkg::ctl_e             state_q, state_d;

  logic                      in_acc, is_query, wr_x, wr_y, wr_g, srch_start;
  logic [XIW-1:0]            x_lower, g_ri;
  logic [YIW-1:0]            y_lower, g_rj;
  bti_pkg::srch_stat_t       x_stat, y_stat;

  logic [VW-1:0]             grid_q [X_POINTS][Y_POINTS];
  logic signed [VW-1:0]      grid_rd_q;

  logic signed [VW-1:0]      qx_q, qy_q;
  logic signed [DW-1:0]      dxa_q, dxa_d, dxb_q, dxb_d, dya_q, dya_d, dyb_q, dyb_d;
  logic signed [DW-1:0]      dxd_q, dxd_d, dyd_q, dyd_d;
  logic signed [NW-1:0]      acc_q, acc_d;
  logic [1:0]                t_q, t_d;
  logic [RW-1:0]             den_q, den_d;
  logic                      neg_q, neg_d;
  logic signed [VW-1:0]      res_q, res_d;
  logic                      sat_q, sat_d, deg_q, deg_d;

  logic                      mul_start, mul_done, div_start, div_done;
  logic signed [NW-1:0]      mul_m, mul_p;
  logic signed [DW-1:0]      mul_d;
  logic [NW-1:0]             prod_abs, acc_abs, div_q, q_r, limit;
  logic [RW-1:0]             div_r;
  logic                      rnd_up, q_sat;
  logic signed [VW-1:0]      q_res;

  logic                      ov_q, ov_d;
  logic signed [VW-1:0]      ores_q;
  logic                      osat_q, odeg_q, load_out;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cnt_q <= bti_pkg::COUNT_RESET;
      y_cnt_q <= bti_pkg::COUNT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bti_pkg::CFG_X_COUNT: x_cnt_q <= cfg_i.data[bti_pkg::CNT_W-1:0];
        bti_pkg::CFG_Y_COUNT: y_cnt_q <= cfg_i.data[bti_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  assign in_i.ready = (state_q == bti_pkg::C_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_query   = in_i.command == bti_pkg::CMD_QUERY;
  assign srch_start = in_acc && is_query;
  assign wr_x = in_acc && (in_i.command == bti_pkg::CMD_WR_X) &&
                (32'(in_i.row_index) < X_POINTS);
  assign wr_y = in_acc && (in_i.command == bti_pkg::CMD_WR_Y) &&
                (32'(in_i.row_index) < Y_POINTS);
  assign wr_g = in_acc && (in_i.command == bti_pkg::CMD_WR_GRID) &&
                (32'(in_i.row_index) < X_POINTS) && (32'(in_i.column_index) < Y_POINTS);

  bti_axis_search #(.POINTS(X_POINTS)) u_x_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_x),
    .wr_addr_i (XIW'(in_i.row_index)),
    .wr_data_i (in_i.entry_value),
    .start_i   (srch_start),
    .query_i   (in_i.query_x),
    .count_i   (x_cnt_q),
    .lower_o   (x_lower),
    .stat_o    (x_stat)
  );

  bti_axis_search #(.POINTS(Y_POINTS)) u_y_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_y),
    .wr_addr_i (YIW'(in_i.row_index)),
    .wr_data_i (in_i.entry_value),
    .start_i   (srch_start),
    .query_i   (in_i.query_y),
    .count_i   (y_cnt_q),
    .lower_o   (y_lower),
    .stat_o    (y_stat)
  );

  bti_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .m_i     (mul_m),
    .d_i     (mul_d),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  bti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_abs),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  // grid memory
  assign g_ri = t_q[0] ? x_lower + XIW'(1) : x_lower;
  assign g_rj = t_q[1] ? y_lower + YIW'(1) : y_lower;

  always_ff @(posedge clk_i) begin
    if (wr_g) begin
      grid_q[XIW'(in_i.row_index)][YIW'(in_i.column_index)] <= in_i.entry_value;
    end
    grid_rd_q <= grid_q[g_ri][g_rj];
  end

  // arithmetic helpers
  assign prod_abs = mul_p[NW-1] ? (~mul_p + NW'(1)) : mul_p;
  assign acc_abs  = acc_q[NW-1] ? (~acc_q + NW'(1)) : acc_q;
  assign rnd_up   = {div_r, 1'b0} >= {1'b0, den_q};
  assign q_r      = div_q + NW'(rnd_up);
  assign limit    = neg_q ? NW'(32'h8000_0000) : NW'(32'h7FFF_FFFF);
  assign q_sat    = q_r > limit;
  assign q_res    = q_sat ? (neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF) :
                    (neg_q ? VW'(~q_r[VW-1:0] + VW'(1)) : q_r[VW-1:0]);

  always_ff @(posedge clk_i) begin
    if (srch_start) begin
      qx_q <= in_i.query_x;
      qy_q <= in_i.query_y;
    end
    dxa_q <= dxa_d;
    dxb_q <= dxb_d;
    dya_q <= dya_d;
    dyb_q <= dyb_d;
    dxd_q <= dxd_d;
    dyd_q <= dyd_d;
    acc_q <= acc_d;
    t_q   <= t_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
    sat_q <= sat_d;
    deg_q <= deg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bti_pkg::C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    dxa_d     = dxa_q;
    dxb_d     = dxb_q;
    dya_d     = dya_q;
    dyb_d     = dyb_q;
    dxd_d     = dxd_q;
    dyd_d     = dyd_q;
    acc_d     = acc_q;
    t_d       = t_q;
    den_d     = den_q;
    neg_d     = neg_q;
    res_d     = res_q;
    sat_d     = sat_q;
    deg_d     = deg_q;
    mul_start = 1'b0;
    mul_m     = bti_pkg::sx_val(grid_rd_q);
    mul_d     = t_q[0] ? dxb_q : dxa_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      bti_pkg::C_IDLE: begin
        if (srch_start) begin
          state_d = bti_pkg::C_SEARCH;
        end
      end
      bti_pkg::C_SEARCH: begin
        if (x_stat.done && y_stat.done) begin
          dxa_d = bti_pkg::sx_delta(x_stat.hi) - bti_pkg::sx_delta(qx_q);
          dxb_d = bti_pkg::sx_delta(qx_q) - bti_pkg::sx_delta(x_stat.lo);
          dya_d = bti_pkg::sx_delta(y_stat.hi) - bti_pkg::sx_delta(qy_q);
          dyb_d = bti_pkg::sx_delta(qy_q) - bti_pkg::sx_delta(y_stat.lo);
          dxd_d = bti_pkg::sx_delta(x_stat.hi) - bti_pkg::sx_delta(x_stat.lo);
          dyd_d = bti_pkg::sx_delta(y_stat.hi) - bti_pkg::sx_delta(y_stat.lo);
          acc_d = '0;
          t_d   = 2'd0;
          if (x_stat.hi == x_stat.lo || y_stat.hi == y_stat.lo) begin
            res_d   = '0;
            sat_d   = 1'b0;
            deg_d   = 1'b1;
            state_d = bti_pkg::C_OUT;
          end else begin
            state_d = bti_pkg::C_GRD;
          end
        end
      end
      bti_pkg::C_GRD: begin
        state_d = bti_pkg::C_MULF;
      end
      bti_pkg::C_MULF: begin
        mul_start = 1'b1;
        state_d   = bti_pkg::C_WAITF;
      end
      bti_pkg::C_WAITF: begin
        if (mul_done) begin
          state_d = bti_pkg::C_MULD;
        end
      end
      bti_pkg::C_MULD: begin
        mul_start = 1'b1;
        mul_m     = mul_p;
        mul_d     = t_q[1] ? dyb_q : dya_q;
        state_d   = bti_pkg::C_WAITD;
      end
      bti_pkg::C_WAITD: begin
        if (mul_done) begin
          acc_d = acc_q + mul_p;
          if (t_q == 2'd3) begin
            state_d = bti_pkg::C_DEN;
          end else begin
            t_d     = t_q + 2'd1;
            state_d = bti_pkg::C_GRD;
          end
        end
      end
      bti_pkg::C_DEN: begin
        mul_start = 1'b1;
        mul_m     = bti_pkg::sx_dlt(dxd_q);
        mul_d     = dyd_q;
        state_d   = bti_pkg::C_WDEN;
      end
      bti_pkg::C_WDEN: begin
        if (mul_done) begin
          den_d   = prod_abs[RW-1:0];
          neg_d   = acc_q[NW-1] ^ mul_p[NW-1];
          state_d = bti_pkg::C_DIV;
        end
      end
      bti_pkg::C_DIV: begin
        div_start = 1'b1;
        state_d   = bti_pkg::C_WDIV;
      end
      bti_pkg::C_WDIV: begin
        if (div_done) begin
          state_d = bti_pkg::C_ROUND;
        end
      end
      bti_pkg::C_ROUND: begin
        res_d   = q_res;
        sat_d   = q_sat;
        deg_d   = 1'b0;
        state_d = bti_pkg::C_OUT;
      end
      bti_pkg::C_OUT: begin
        if (!ov_q) begin
          load_out = 1'b1;
          state_d  = bti_pkg::C_IDLE;
        end
      end
      default: state_d = bti_pkg::C_IDLE;
    endcase
  end

  // output register
  assign ov_d = load_out || (ov_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ores_q <= res_q;
      osat_q <= sat_q;
      odeg_q <= deg_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.result_value = ores_q;
  assign out_o.saturated    = osat_q;
  assign out_o.degenerate   = odeg_q;

endmodule

>>> src/bti_axis_search.sv
`timescale 1ns / 1ps

module bti_axis_search #(
  parameter int POINTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [$clog2(POINTS)-1:0]         wr_addr_i,
  input  logic [bti_pkg::VAL_W-1:0]         wr_data_i,
  input  logic                              start_i,
  input  logic signed [bti_pkg::VAL_W-1:0]  query_i,
  input  logic [bti_pkg::CNT_W-1:0]         count_i,
  output logic [$clog2(POINTS)-1:0]         lower_o,
  output bti_pkg::srch_stat_t               stat_o
);

  localparam int IW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS + 1);
  localparam int EW = ((CW > bti_pkg::CNT_W) ? CW : bti_pkg::CNT_W) + 1;

  logic [bti_pkg::VAL_W-1:0]        mem_q [POINTS];
  logic [bti_pkg::VAL_W-1:0]        rd_data_q;
  logic [IW-1:0]                    rd_addr;
  bti_pkg::srch_e                   state_q, state_d;
  logic [IW-1:0]                    idx_q, idx_d;
  logic [IW-1:0]                    lower_q, lower_d;
  logic signed [bti_pkg::VAL_W-1:0] lo_q, lo_d, hi_q, hi_d, query_q;
  logic                             done_q, done_d;
  logic [EW-1:0]                    cnt_ext;
  logic [CW-1:0]                    n_used;
  logic                             gt, last;

  assign cnt_ext = EW'(count_i);
  assign n_used  = (cnt_ext < EW'(2)) ? CW'(2) :
                   ((cnt_ext > EW'(POINTS)) ? CW'(POINTS) : CW'(cnt_ext));
  assign gt      = $signed(rd_data_q) > query_q;
  assign last    = CW'(idx_q) == (n_used - CW'(2));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr];
    if (start_i) begin
      query_q <= query_i;
    end
    idx_q   <= idx_d;
    lower_q <= lower_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bti_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    lower_d = lower_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    done_d  = done_q;
    rd_addr = idx_q;
    unique case (state_q)
      bti_pkg::S_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          done_d  = 1'b0;
          state_d = bti_pkg::S_RD;
        end
      end
      bti_pkg::S_RD: begin
        state_d = bti_pkg::S_CMP;
      end
      bti_pkg::S_CMP: begin
        if (gt) begin
          lower_d = (idx_q == '0) ? '0 : idx_q - IW'(1);
          state_d = bti_pkg::S_RDLO;
        end else if (last) begin
          lower_d = IW'(n_used - CW'(2));
          state_d = bti_pkg::S_RDLO;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = bti_pkg::S_RD;
        end
      end
      bti_pkg::S_RDLO: begin
        rd_addr = lower_q;
        state_d = bti_pkg::S_RDHI;
      end
      bti_pkg::S_RDHI: begin
        rd_addr = lower_q + IW'(1);
        lo_d    = rd_data_q;
        state_d = bti_pkg::S_CAPHI;
      end
      bti_pkg::S_CAPHI: begin
        hi_d    = rd_data_q;
        done_d  = 1'b1;
        state_d = bti_pkg::S_IDLE;
      end
      default: state_d = bti_pkg::S_IDLE;
    endcase
  end

  assign lower_o     = lower_q;
  assign stat_o.done = done_q;
  assign stat_o.lo   = lo_q;
  assign stat_o.hi   = hi_q;

endmodule

>>> src/bti_mul.sv
`timescale 1ns / 1ps

module bti_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [bti_pkg::NUM_W-1:0]    m_i,
  input  logic signed [bti_pkg::DELTA_W-1:0]  d_i,
  output logic                                done_o,
  output logic signed [bti_pkg::NUM_W-1:0]    prod_o
);

  localparam int NW = bti_pkg::NUM_W;
  localparam int DW = bti_pkg::DELTA_W;
  localparam int KW = bti_pkg::MUL_CNT_W;

  bti_pkg::mul_e   state_q, state_d;
  logic [KW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   m_q, m_d, p_q, p_d;
  logic [DW-1:0]   d_q, d_d, d_mag;
  logic            neg_q, neg_d, done_q, done_d;

  assign d_mag = d_i[DW-1] ? (~d_i + DW'(1)) : d_i;

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    m_q   <= m_d;
    p_q   <= p_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bti_pkg::M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    p_d     = p_q;
    d_d     = d_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    unique case (state_q)
      bti_pkg::M_IDLE: begin
        if (start_i) begin
          m_d     = m_i;
          d_d     = d_mag;
          neg_d   = d_i[DW-1];
          p_d     = '0;
          cnt_d   = '0;
          state_d = bti_pkg::M_RUN;
        end
      end
      bti_pkg::M_RUN: begin
        if (d_q[0]) begin
          p_d = p_q + m_q;
        end
        m_d   = m_q << 1;
        d_d   = d_q >> 1;
        cnt_d = cnt_q + KW'(1);
        if (cnt_q == KW'(bti_pkg::MUL_STEPS - 1)) begin
          state_d = bti_pkg::M_SIGN;
        end
      end
      bti_pkg::M_SIGN: begin
        if (neg_q) begin
          p_d = ~p_q + NW'(1);
        end
        done_d  = 1'b1;
        state_d = bti_pkg::M_IDLE;
      end
      default: state_d = bti_pkg::M_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

>>> src/bti_div.sv
`timescale 1ns / 1ps

module bti_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bti_pkg::NUM_W-1:0]     num_i,
  input  logic [bti_pkg::DEN_W-1:0]     den_i,
  output logic                          done_o,
  output logic [bti_pkg::NUM_W-1:0]     quo_o,
  output logic [bti_pkg::DEN_W-1:0]     rem_o
);

  localparam int NW = bti_pkg::NUM_W;
  localparam int RW = bti_pkg::DEN_W;
  localparam int KW = bti_pkg::DIV_CNT_W;

  bti_pkg::div_e  state_q, state_d;
  logic [KW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]  n_q, n_d, q_q, q_d;
  logic [RW-1:0]  r_q, r_d, den_q, den_d;
  logic [RW:0]    sh;
  logic           fits, done_q, done_d;

  assign sh   = {r_q, n_q[NW-1]};
  assign fits = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    n_q   <= n_d;
    q_q   <= q_d;
    r_q   <= r_d;
    den_q <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bti_pkg::D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    q_d     = q_q;
    r_d     = r_q;
    den_d   = den_q;
    done_d  = 1'b0;
    unique case (state_q)
      bti_pkg::D_IDLE: begin
        if (start_i) begin
          n_d     = num_i;
          den_d   = den_i;
          q_d     = '0;
          r_d     = '0;
          cnt_d   = '0;
          state_d = bti_pkg::D_RUN;
        end
      end
      bti_pkg::D_RUN: begin
        r_d   = fits ? RW'(sh - {1'b0, den_q}) : sh[RW-1:0];
        q_d   = {q_q[NW-2:0], fits};
        n_d   = n_q << 1;
        cnt_d = cnt_q + KW'(1);
        if (cnt_q == KW'(bti_pkg::DIV_STEPS - 1)) begin
          done_d  = 1'b1;
          state_d = bti_pkg::D_IDLE;
        end
      end
      default: state_d = bti_pkg::D_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;

endmodule

>>> src/bti_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bti_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic [1:0]                      in_command_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [bti_pkg::VAL_W-1:0]       out_result_i,
  input logic                            out_saturated_i,
  input logic                            out_degenerate_i
);

  `BTI_ASSERT_SAME(a_deg_zero, out_valid_i && out_degenerate_i, out_result_i == '0 && !out_saturated_i, "degenerate beat carries a value")
  `BTI_ASSERT_SAME(a_sat_rail, out_valid_i && out_saturated_i, (out_result_i == 32'h7FFF_FFFF || out_result_i == 32'h8000_0000), "saturated beat off the rail")
  `BTI_ASSERT_NEXT(a_query_busy, in_valid_i && in_ready_i && in_command_i == bti_pkg::CMD_QUERY, !in_ready_i, "ready after query beat")
  `BTI_ASSERT_NEXT(a_write_free, in_valid_i && in_ready_i && in_command_i != bti_pkg::CMD_QUERY, in_ready_i, "busy after write beat")
  `BTI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_result_i), "stalled result changed")

endmodule

bind bilinear_table_interpolator_top bti_checker u_bti_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_command_i     (in_i.command),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_result_i     (out_o.result_value),
  .out_saturated_i  (out_o.saturated),
  .out_degenerate_i (out_o.degenerate)
);

>>> verif/tb_bilinear_table_interpolator_top.sv
`timescale 1ns / 1ps

module tb_bilinear_table_interpolator_top;

  localparam int NPTS       = 16;
  localparam int IDLE_LIMIT = 6000;
  localparam int VW         = bti_pkg::VAL_W;
  localparam int CNTW       = bti_pkg::CNT_W;
  localparam int CIW        = bti_pkg::CFG_IDX_W;
  localparam int CDW        = bti_pkg::CFG_DATA_W;

  // indexes past the register list, expected to be ignored
  localparam logic [CIW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CIW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 sat;
    logic                 degen;
  } lut_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bti_cfg_if cfg_if ();
  bti_in_if  in_if ();
  bti_out_if out_if ();

  bilinear_table_interpolator_top #(.X_POINTS(NPTS), .Y_POINTS(NPTS)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the table contents and counts
  logic signed [VW-1:0] xbp_m [NPTS];
  logic signed [VW-1:0] ybp_m [NPTS];
  logic signed [VW-1:0] grid_m [NPTS][NPTS];
  logic [CNTW-1:0]      xcnt_m;
  logic [CNTW-1:0]      ycnt_m;

  lut_result_t pending_q[$];
  int errors, n_items, n_queries, n_results, n_sat, n_degen, n_cfg;
  int idle_cycles;

  function automatic int axis_len(logic [CNTW-1:0] c);
    if (c < 2) return 2;
    if (c > NPTS) return NPTS;
    return int'(c);
  endfunction

  function automatic int lower_index(logic signed [VW-1:0] bp[NPTS], logic [CNTW-1:0] c,
                                     logic signed [VW-1:0] q);
    int n, upper;
    n = axis_len(c);
    upper = n - 1;
    for (int i = 0; i + 1 < n; i++) begin
      if (bp[i] > q) begin
        upper = i;
        break;
      end
    end
    return (upper == 0) ? 0 : upper - 1;
  endfunction

  function automatic logic signed [127:0] wide(longint v);
    logic signed [127:0] r;
    r = v;
    return r;
  endfunction

  function automatic lut_result_t interpolate(logic signed [VW-1:0] qx,
                                              logic signed [VW-1:0] qy);
    lut_result_t r;
    int i1, j1;
    longint x, y, x1, x2, y1, y2;
    logic signed [127:0] num, den;
    logic [127:0] nm, dm, qt, rm, lim;
    logic neg;
    i1 = lower_index(xbp_m, xcnt_m, qx);
    j1 = lower_index(ybp_m, ycnt_m, qy);
    x = qx; y = qy;
    x1 = xbp_m[i1]; x2 = xbp_m[i1+1];
    y1 = ybp_m[j1]; y2 = ybp_m[j1+1];
    r.value = '0; r.sat = 1'b0; r.degen = 1'b0;
    if (x2 == x1 || y2 == y1) begin
      r.degen = 1'b1;
      return r;
    end
    num = wide(grid_m[i1][j1])     * wide(x2 - x) * wide(y2 - y)
        + wide(grid_m[i1+1][j1])   * wide(x - x1) * wide(y2 - y)
        + wide(grid_m[i1][j1+1])   * wide(x2 - x) * wide(y - y1)
        + wide(grid_m[i1+1][j1+1]) * wide(x - x1) * wide(y - y1);
    den = wide(x2 - x1) * wide(y2 - y1);
    neg = num[127] ^ den[127];
    nm = num[127] ? -num : num;
    dm = den[127] ? -den : den;
    qt = nm / dm;
    rm = nm % dm;
    if (rm >= dm - rm) qt = qt + 1;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (qt > lim) begin
      r.sat = 1'b1;
      r.value = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.value = neg ? -qt[31:0] : qt[31:0];
    end
    return r;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_item(bti_pkg::cmd_e cmd, logic signed [VW-1:0] qx,
                           logic signed [VW-1:0] qy, logic [3:0] row, logic [3:0] col,
                           logic signed [VW-1:0] val);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.query_x      <= qx;
    in_if.query_y      <= qy;
    in_if.row_index    <= row;
    in_if.column_index <= col;
    in_if.entry_value  <= val;
    do @(posedge clk_i); while (!in_if.ready);
    n_items++;
    case (cmd)
      bti_pkg::CMD_QUERY: begin
        pending_q.push_back(interpolate(qx, qy));
        n_queries++;
      end
      bti_pkg::CMD_WR_X:    xbp_m[row] = val;
      bti_pkg::CMD_WR_Y:    ybp_m[row] = val;
      bti_pkg::CMD_WR_GRID: grid_m[row][col] = val;
      default: ;
    endcase
  endtask

  task automatic write_entry(bti_pkg::cmd_e cmd, int row, int col, logic signed [VW-1:0] val);
    send_item(cmd, $urandom, $urandom, row[3:0], col[3:0], val);
  endtask

  task automatic query(logic signed [VW-1:0] qx, logic signed [VW-1:0] qy);
    send_item(bti_pkg::CMD_QUERY, qx, qy, 4'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [CDW-1:0] data);
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_cfg++;
    if (idx == bti_pkg::CFG_X_COUNT) xcnt_m = data[CNTW-1:0];
    else if (idx == bti_pkg::CFG_Y_COUNT) ycnt_m = data[CNTW-1:0];
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    logic signed [VW-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 2) != 0) v = v >>> $urandom_range(4, 20);
    return v;
  endfunction

  // sorted axis mostly, sometimes with a repeated point or fully scrambled
  task automatic load_axis(bti_pkg::cmd_e cmd);
    int mode, dup, scale;
    longint base, step;
    logic signed [VW-1:0] v [NPTS];
    mode  = $urandom_range(0, 9);
    scale = $urandom_range(0, 26);
    step  = $urandom_range(1, (1 << scale));
    base  = longint'($signed($urandom_range(0, 1 << 20))) - 8 * step;
    for (int i = 0; i < NPTS; i++) v[i] = VW'(base + i * step);
    if (mode == 8) begin
      dup = $urandom_range(0, NPTS - 2);
      v[dup+1] = v[dup];
    end else if (mode == 9) begin
      for (int i = 0; i < NPTS; i++) v[i] = rand_value();
    end
    for (int i = 0; i < NPTS; i++) write_entry(cmd, i, 0, v[i]);
  endtask

  function automatic logic signed [VW-1:0] rand_coord(logic signed [VW-1:0] bp[NPTS],
                                                      logic [CNTW-1:0] c);
    int k, r;
    longint p;
    logic signed [VW-1:0] off;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, axis_len(c) - 1);
    if (r == 0) return $urandom;
    if (r == 1) return bp[k];
    off = $urandom;
    p = longint'(bp[k]) + longint'(off >>> $urandom_range(4, 31));
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return VW'(p);
  endfunction

  always @(posedge clk_i) begin
    int rl;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      rl = $urandom_range(0, 99);
      out_if.ready <= (rl < 70) || (rl >= 97 && out_if.ready);
    end
  end

  always @(posedge clk_i) begin
    lut_result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: value %h", out_if.result_value);
      end else begin
        e = pending_q.pop_front();
        if (e.sat) n_sat++;
        if (e.degen) n_degen++;
        if (out_if.result_value !== e.value || out_if.saturated !== e.sat ||
            out_if.degenerate !== e.degen) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp value %h sat %b degen %b, got value %h sat %b degen %b",
                     e.value, e.sat, e.degen, out_if.result_value, out_if.saturated,
                     out_if.degenerate);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog timeout, %0d results outstanding", pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic init_tables();
    for (int i = 0; i < NPTS; i++) write_entry(bti_pkg::CMD_WR_X, i, 0, i << 16);
    for (int i = 0; i < NPTS; i++) write_entry(bti_pkg::CMD_WR_Y, i, 0, i << 16);
    for (int i = 0; i < NPTS; i++)
      for (int j = 0; j < NPTS; j++) write_entry(bti_pkg::CMD_WR_GRID, i, j, rand_value());
  endtask

  task automatic test_directed();
    query(0, 0);
    query(32'sh0001_0000, 32'sh0001_0000);
    query(32'sh0000_8000, 32'sh0000_c000);
    query(32'sh8000_0000, 32'sh7fff_ffff);
    query(32'sh7fff_ffff, 32'sh8000_0000);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) write_entry(bti_pkg::CMD_WR_GRID, i, j, 32'sh7fff_ffff);
    query(32'sh7fff_ffff, 32'sh7fff_ffff);
    query(32'sh0000_4000, 32'sh0000_4000);
    write_entry(bti_pkg::CMD_WR_GRID, 1, 1, 32'sh8000_0000);
    write_entry(bti_pkg::CMD_WR_GRID, 0, 0, 32'sh8000_0000);
    query(32'sh8000_0000, 32'sh8000_0000);
    query(32'sh7fff_ffff, 32'sh8000_0000);
    // equal breakpoints on x, then on y
    write_entry(bti_pkg::CMD_WR_X, 1, 0, 0);
    query(32'sh0000_2000, 32'sh0000_2000);
    write_entry(bti_pkg::CMD_WR_X, 1, 0, 32'sh0001_0000);
    write_entry(bti_pkg::CMD_WR_Y, 1, 0, 0);
    query(32'sh0000_2000, 32'sh0000_2000);
    write_entry(bti_pkg::CMD_WR_Y, 1, 0, 32'sh0001_0000);
    query(32'sh0000_2000, 32'shffff_f000);
  endtask

  task automatic test_counts();
    logic [CDW-1:0] d;
    int settings [6][2] = '{'{0, 1}, '{16, 16}, '{17, 31}, '{2, 16}, '{16, 2}, '{9, 5}};
    for (int s = 0; s < 6; s++) begin
      d = $urandom;
      write_reg(bti_pkg::CFG_X_COUNT, {d[CDW-1:CNTW], CNTW'(settings[s][0])});
      d = $urandom;
      write_reg(bti_pkg::CFG_Y_COUNT, {d[CDW-1:CNTW], CNTW'(settings[s][1])});
      write_reg(CFG_SPARE_LO, $urandom);
      write_reg(CFG_SPARE_HI, $urandom);
      repeat (4) query(rand_coord(xbp_m, xcnt_m), rand_coord(ybp_m, ycnt_m));
    end
  endtask

  task automatic test_random();
    int r, c;
    logic [CDW-1:0] d;
    for (int ph = 0; ph < 12; ph++) begin
      r = $urandom_range(0, 3);
      c = (r == 0) ? 2 : (r == 1) ? 16 : $urandom_range(0, 31);
      d = $urandom;
      write_reg(bti_pkg::CFG_X_COUNT, {d[CDW-1:CNTW], CNTW'(c)});
      r = $urandom_range(0, 3);
      c = (r == 0) ? 2 : (r == 1) ? 16 : $urandom_range(0, 31);
      d = $urandom;
      write_reg(bti_pkg::CFG_Y_COUNT, {d[CDW-1:CNTW], CNTW'(c)});
      load_axis(bti_pkg::CMD_WR_X);
      load_axis(bti_pkg::CMD_WR_Y);
      repeat (20)
        write_entry(bti_pkg::CMD_WR_GRID, $urandom_range(0, 15), $urandom_range(0, 15),
                    rand_value());
      repeat (45) begin
        r = $urandom_range(0, 9);
        if (r == 0) write_entry(bti_pkg::CMD_WR_GRID, $urandom_range(0, 15),
                                $urandom_range(0, 15), rand_value());
        else if (r == 1) write_entry(bti_pkg::cmd_e'($urandom_range(1, 2)),
                                     $urandom_range(0, 15), 0, rand_value());
        else query(rand_coord(xbp_m, xcnt_m), rand_coord(ybp_m, ycnt_m));
      end
    end
  endtask

  initial begin
    errors = 0; n_items = 0; n_queries = 0; n_results = 0;
    n_sat = 0; n_degen = 0; n_cfg = 0; idle_cycles = 0;
    xcnt_m = bti_pkg::COUNT_RESET;
    ycnt_m = bti_pkg::COUNT_RESET;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.command       <= bti_pkg::CMD_QUERY;
    in_if.query_x       <= '0;
    in_if.query_y       <= '0;
    in_if.row_index     <= '0;
    in_if.column_index  <= '0;
    in_if.entry_value   <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    init_tables();
    test_directed();
    test_counts();
    test_random();

    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d items (%0d queries, %0d results), %0d register writes", n_items, n_queries,
             n_results, n_cfg);
    $display("%0d saturated and %0d degenerate results seen, %0d errors", n_sat, n_degen,
             errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
